>>> rtl/sfr_pkg.sv
// shared types and constants for the stream find and replace block
`timescale 1ns / 1ps

package sfr_pkg;

    // widths fixed by the 64-bit byte registers
    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int PEND_DEPTH      = MAX_PATTERN - 1;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [3:0] MAX_PAT_LEN  = 4'(MAX_PATTERN);
    localparam logic [3:0] MAX_REPL_LEN = 4'(MAX_REPLACEMENT);

    typedef enum logic [2:0] {
        CFG_PATTERN_LENGTH     = 3'd0,
        CFG_PATTERN_BYTES      = 3'd1,
        CFG_REPLACEMENT_LENGTH = 3'd2,
        CFG_REPLACEMENT_BYTES  = 3'd3
    } t_cfg_idx;

    // one classified word group: up to eight bytes to send, low byte first
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  cnt;
        logic        last;
    } t_desc;

endpackage

>>> rtl/sfr_front.sv
// front end: config registers, pending buffer and match classification
`timescale 1ns / 1ps

module sfr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_accept,
    input  logic [7:0]         i_text_byte,
    input  logic               i_text_last,
    output logic               o_q_push,
    output sfr_pkg::t_desc     o_q_desc
);

    logic [3:0]  r_plen;
    logic [63:0] r_pbytes;
    logic [3:0]  r_rlen;
    logic [63:0] r_rbytes;
    logic [7:0]  r_pend [sfr_pkg::PEND_DEPTH];
    logic [2:0]  r_pend_cnt;
    logic [2:0]  n_pend_cnt;

    logic [3:0]  plen_eff;
    logic [3:0]  rlen_eff;
    logic [3:0]  n0;
    logic [3:0]  n;
    logic [7:0]  buf_b [sfr_pkg::MAX_PATTERN];
    logic [63:0] buf_word;
    logic [63:0] shifted;
    logic [7:0]  ok_v;
    logic [7:0]  good;
    logic [3:0]  s_first;
    logic        full_match;

    always_comb begin
        plen_eff = (r_plen > sfr_pkg::MAX_PAT_LEN) ? sfr_pkg::MAX_PAT_LEN : r_plen;
        rlen_eff = (r_rlen > sfr_pkg::MAX_REPL_LEN) ? sfr_pkg::MAX_REPL_LEN : r_rlen;
        // an empty pattern ignores whatever is pending
        n0 = (plen_eff == 4'd0) ? 4'd0 : {1'b0, r_pend_cnt};
        n  = n0 + 4'd1;
        for (int i = 0; i < sfr_pkg::MAX_PATTERN; i++) begin
            if (4'(i) == n0) begin
                buf_b[i] = i_text_byte;
            end else if (i < sfr_pkg::PEND_DEPTH) begin
                buf_b[i] = r_pend[i];
            end else begin
                buf_b[i] = 8'h00;
            end
            buf_word[8*i +: 8] = buf_b[i];
        end
        // tail starting at s must be a proper prefix of the pattern
        for (int s = 0; s < sfr_pkg::MAX_PATTERN; s++) begin
            ok_v[s] = 1'b1;
            for (int i = 0; i < sfr_pkg::MAX_PATTERN - s; i++) begin
                if ((4'(s + i) < n) && (buf_b[s + i] != r_pbytes[8*i +: 8])) begin
                    ok_v[s] = 1'b0;
                end
            end
            good[s] = (4'(s) < n) && ((n - 4'(s)) < plen_eff) && ok_v[s];
        end
        s_first = n;
        for (int s = sfr_pkg::MAX_PATTERN - 1; s >= 0; s--) begin
            if (good[s]) begin
                s_first = 4'(s);
            end
        end
        full_match = (n == plen_eff) && ok_v[0];
        shifted    = buf_word >> {s_first, 3'b000};

        o_q_desc.last = i_text_last;
        if (full_match) begin
            o_q_desc.data = r_rbytes;
            o_q_desc.cnt  = rlen_eff;
            n_pend_cnt    = 3'd0;
        end else if (i_text_last) begin
            o_q_desc.data = buf_word;
            o_q_desc.cnt  = n;
            n_pend_cnt    = 3'd0;
        end else begin
            o_q_desc.data = buf_word;
            o_q_desc.cnt  = s_first;
            n_pend_cnt    = 3'(n - s_first);
        end
        o_q_push = i_accept && ((o_q_desc.cnt != 4'd0) || i_text_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen     <= 4'd1;
            r_pbytes   <= 64'd0;
            r_rlen     <= 4'd0;
            r_rbytes   <= 64'd0;
            r_pend_cnt <= 3'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sfr_pkg::CFG_PATTERN_LENGTH: begin
                    r_plen     <= i_cfg_data[3:0];
                    r_pend_cnt <= 3'd0;
                end
                sfr_pkg::CFG_PATTERN_BYTES: begin
                    r_pbytes   <= i_cfg_data;
                    r_pend_cnt <= 3'd0;
                end
                sfr_pkg::CFG_REPLACEMENT_LENGTH: begin
                    r_rlen <= i_cfg_data[3:0];
                end
                sfr_pkg::CFG_REPLACEMENT_BYTES: begin
                    r_rbytes <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end else if (i_accept) begin
            r_pend_cnt <= n_pend_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int j = 0; j < sfr_pkg::PEND_DEPTH; j++) begin
                r_pend[j] <= shifted[8*j +: 8];
            end
        end
    end

endmodule

>>> rtl/sfr_queue.sv
// small word-group queue between the front end and the emitter
`timescale 1ns / 1ps

module sfr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sfr_pkg::t_desc i_desc,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output sfr_pkg::t_desc o_desc
);

    localparam int AW = $clog2(sfr_pkg::QUEUE_DEPTH);

    sfr_pkg::t_desc r_mem [sfr_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [AW:0]    r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == (AW + 1)'(sfr_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_desc  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

endmodule

>>> rtl/sfr_emit.sv
// back end: sends the bytes of each word group one word at a time
`timescale 1ns / 1ps

module sfr_emit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  sfr_pkg::t_desc i_q_desc,
    output logic           o_q_pop,
    output logic           empty,
    input  logic           pop,
    output logic [7:0]     o_out_byte,
    output logic           o_out_valid_byte,
    output logic           o_out_last
);

    logic [63:0] r_data;
    logic [3:0]  r_rem;
    logic        r_vb;
    logic        r_last;
    logic        load;

    // refill when idle or when the final word of the group leaves
    assign load    = !i_q_empty && ((r_rem == 4'd0) || (pop && r_rem == 4'd1));
    assign o_q_pop = load;

    assign empty            = (r_rem == 4'd0);
    assign o_out_byte       = r_data[7:0];
    assign o_out_valid_byte = r_vb;
    assign o_out_last       = r_last && (r_rem == 4'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 4'd0;
        end else if (load) begin
            // an empty group with the last mark becomes a single marker word
            r_rem <= (i_q_desc.cnt == 4'd0) ? 4'd1 : i_q_desc.cnt;
        end else if (pop && r_rem != 4'd0) begin
            r_rem <= r_rem - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            // the end marker carries a zero byte
            r_data <= (i_q_desc.cnt == 4'd0) ? 64'd0 : i_q_desc.data;
            r_vb   <= (i_q_desc.cnt != 4'd0);
            r_last <= i_q_desc.last;
        end else if (pop && r_rem != 4'd0) begin
            r_data <= {8'h00, r_data[63:8]};
        end
    end

endmodule

>>> rtl/stream_find_replace.sv
// an accepted byte's group is queued, then loaded into the emitter register when the emitter is idle
// throughput: one byte accepted per cycle while the 4-entry group queue has room
// output side sends one word per cycle while pop is high; k words from one byte hold the emitter for k pops
// reset: synchronous active low, clears pending count and queue, restores config defaults
`timescale 1ns / 1ps

module stream_find_replace (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_text_byte,
    input  logic        i_text_last,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_out_valid_byte,
    output logic        o_out_last
);

    logic           accept;
    logic           q_push;
    logic           q_pop;
    logic           q_empty;
    sfr_pkg::t_desc q_in;
    sfr_pkg::t_desc q_out;

    assign accept = push && !full;

    sfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_text_byte (i_text_byte),
        .i_text_last (i_text_last),
        .o_q_push    (q_push),
        .o_q_desc    (q_in)
    );

    sfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (q_in),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_desc  (q_out)
    );

    sfr_emit u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_q_desc         (q_out),
        .o_q_pop          (q_pop),
        .empty            (empty),
        .pop              (pop),
        .o_out_byte       (o_out_byte),
        .o_out_valid_byte (o_out_valid_byte),
        .o_out_last       (o_out_last)
    );

endmodule

>>> rtl/sfr_checker.sv
// port-level checks for the stream find and replace block, bound to the top level
`timescale 1ns / 1ps

module sfr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_byte,
    input logic       o_out_valid_byte,
    input logic       o_out_last
);

    // nothing to read right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result present right after reset");

    // a stalled word stays put
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte)
            && $stable(o_out_valid_byte) && $stable(o_out_last)))
        else $error("stalled word changed");

    // a word without data is only the end marker
    a_marker_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_valid_byte) |-> o_out_last)
        else $error("empty word without last mark");

    // the queue only fills up by taking a byte
    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose with no byte pushed");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (.*);

>>> tb/tb_stream_find_replace.sv
// self-checking testbench for the stream find and replace block
`timescale 1ns / 1ps

module tb_stream_find_replace;

    localparam logic [2:0] CFG_SPARE_IDX = 3'd5;  // decodes to no register
    localparam int SETTLE_CYCLES = 8;
    localparam int PLAN_ROWS     = 36;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 47;
    localparam int HOLD_CYCLES   = 120;

    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       last;
    } t_word;

    typedef struct packed {
        logic        is_cfg;
        logic [2:0]  idx;
        logic [63:0] val;
        logic [7:0]  text;
        logic        text_end;
        logic        known;
        t_word       want;
    } t_row;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_we         = 1'b0;
    logic [2:0]  i_cfg_index      = '0;
    logic [63:0] i_cfg_data       = '0;
    logic        push             = 1'b0;
    logic [7:0]  i_text_byte      = '0;
    logic        i_text_last      = 1'b0;
    logic        pop              = 1'b0;
    logic        full;
    logic        empty;
    logic [7:0]  o_out_byte;
    logic        o_out_valid_byte;
    logic        o_out_last;

    stream_find_replace u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .push             (push),
        .full             (full),
        .i_text_byte      (i_text_byte),
        .i_text_last      (i_text_last),
        .empty            (empty),
        .pop              (pop),
        .o_out_byte       (o_out_byte),
        .o_out_valid_byte (o_out_valid_byte),
        .o_out_last       (o_out_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // shadow of the block: registers and pending match bytes
    logic [3:0]  pat_len;
    logic [63:0] pat_bytes;
    logic [3:0]  repl_len;
    logic [63:0] repl_bytes;
    logic [7:0]  pend [0:sfr_pkg::PEND_DEPTH-1];
    int          pend_n;

    t_word fresh [$];      // words caused by the latest text byte
    t_word rewritten [$];  // words still owed by the block, oldest first

    int idle_pct   = 0;
    int stall_pct  = 0;
    bit hold_rx    = 1'b0;
    int errors     = 0;
    int texts_sent = 0;
    int words_seen = 0;
    int cfg_writes = 0;
    int full_waits = 0;

    // directed rows; known rows carry the one word they must give
    t_row plan [PLAN_ROWS] = '{
        // reset setup: one-byte pattern 00, empty replacement
        '{1'b0, '0, '0, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},  // deleted, end marker
        '{1'b0, '0, '0, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1}},
        '{1'b1, sfr_pkg::CFG_REPLACEMENT_LENGTH, 64'd3, '0, 1'b0, 1'b0, '0},
        '{1'b1, sfr_pkg::CFG_REPLACEMENT_BYTES, 64'h5A5958, '0, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'h00, 1'b0, 1'b0, '0},
        '{1'b1, sfr_pkg::CFG_PATTERN_LENGTH, 64'd3, '0, 1'b0, 1'b0, '0},
        '{1'b1, sfr_pkg::CFG_PATTERN_BYTES, 64'h636261, '0, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'h61, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'h62, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'h78, 1'b0, 1'b0, '0},  // broken prefix released
        '{1'b0, '0, '0, 8'h61, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'h62, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'h63, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'h61, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'h61, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'h62, 1'b1, 1'b0, '0},  // flush of pending at end
        '{1'b1, sfr_pkg::CFG_PATTERN_LENGTH, 64'd0, '0, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'h41, 1'b1, 1'b1, '{8'h41, 1'b1, 1'b1}},
        '{1'b1, sfr_pkg::CFG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, 1'b0, '0},
        '{1'b1, sfr_pkg::CFG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, 1'b0, '0},
        '{1'b1, sfr_pkg::CFG_REPLACEMENT_LENGTH, 64'd15, '0, 1'b0, 1'b0, '0},
        '{1'b1, sfr_pkg::CFG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF, '0, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'hFF, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'hFF, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'hFF, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'hFF, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'hFF, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'hFF, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'hFF, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'hFF, 1'b0, 1'b0, '0},  // full match, eight words
        '{1'b1, CFG_SPARE_IDX, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'h7F, 1'b1, 1'b1, '{8'h7F, 1'b1, 1'b1}},
        '{1'b0, '0, '0, 8'hFF, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'hFF, 1'b0, 1'b0, '0},
        '{1'b1, sfr_pkg::CFG_PATTERN_LENGTH, 64'd8, '0, 1'b0, 1'b0, '0},  // drops pending
        '{1'b0, '0, '0, 8'h01, 1'b1, 1'b1, '{8'h01, 1'b1, 1'b1}}
    };

    initial begin
        pat_len    = 4'd1;
        pat_bytes  = '0;
        repl_len   = '0;
        repl_bytes = '0;
        pend_n     = 0;
    end

    function automatic bit is_pat_head(input logic [7:0] w [0:8], input int s, input int n);
        for (int i = 0; i < n; i++)
            if (w[s + i] != pat_bytes[8 * i +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void emit(input logic [7:0] d);
        fresh.push_back('{data: d, has_data: 1'b1, last: 1'b0});
    endfunction

    // words caused by one text byte; updates the pending buffer
    function automatic void predict_text(input logic [7:0] b, input logic fin);
        logic [7:0] held [0:8];
        t_word      tail;
        int         n;
        int         start;
        int         plen;
        int         rlen;
        fresh.delete();
        plen  = (pat_len > sfr_pkg::MAX_PAT_LEN) ? sfr_pkg::MAX_PATTERN : int'(pat_len);
        rlen  = (repl_len > sfr_pkg::MAX_REPL_LEN) ? sfr_pkg::MAX_REPLACEMENT
                                                    : int'(repl_len);
        n     = (pend_n >= sfr_pkg::MAX_PATTERN) ? sfr_pkg::PEND_DEPTH : pend_n;
        start = 0;
        if (plen == 0)
            n = 0;
        for (int i = 0; i < n; i++)
            held[i] = pend[i];
        held[n] = b;
        n++;
        if (plen == 0) begin
            emit(held[0]);
            n = 0;
        end else if (n == plen && is_pat_head(held, 0, n)) begin
            for (int i = 0; i < rlen; i++)
                emit(repl_bytes[8 * i +: 8]);
            n = 0;
        end else begin
            // release oldest bytes until the rest could still grow into a match
            while (n > 0 && !(n < plen && is_pat_head(held, start, n))) begin
                emit(held[start]);
                start++;
                n--;
            end
        end
        if (fin) begin
            while (n > 0) begin
                emit(held[start]);
                start++;
                n--;
            end
            if (fresh.size() == 0)
                fresh.push_back('{data: 8'h00, has_data: 1'b0, last: 1'b0});
            tail      = fresh.pop_back();
            tail.last = 1'b1;
            fresh.push_back(tail);
        end
        for (int i = 0; i < n; i++)
            pend[i] = held[start + i];
        pend_n = n;
    endfunction

    task automatic flag(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_word();
        t_word w;
        if (rewritten.size() == 0) begin
            flag($sformatf("unexpected word %h valid %b last %b",
                           o_out_byte, o_out_valid_byte, o_out_last));
        end else begin
            w = rewritten.pop_front();
            if (o_out_byte !== w.data)
                flag($sformatf("out_byte %h, want %h", o_out_byte, w.data));
            if (o_out_valid_byte !== w.has_data)
                flag($sformatf("out_valid_byte %b, want %b", o_out_valid_byte, w.has_data));
            if (o_out_last !== w.last)
                flag($sformatf("out_last %b, want %b", o_out_last, w.last));
        end
        words_seen++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            check_word();
        pop <= !hold_rx && ($urandom_range(99) >= stall_pct);
    end

    task automatic send_text(input logic [7:0] b, input logic fin, input logic known,
                             input t_word want);
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_text_byte <= b;
        i_text_last <= fin;
        @(posedge i_clk);
        while (full) begin
            full_waits++;
            @(posedge i_clk);
        end
        predict_text(b, fin);
        if (known)
            rewritten.push_back(want);
        else
            foreach (fresh[i]) rewritten.push_back(fresh[i]);
        texts_sent++;
    endtask

    // stop sending and let the block run dry before touching registers
    task automatic settle();
        push <= 1'b0;
        while (rewritten.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            sfr_pkg::CFG_PATTERN_LENGTH: begin
                pat_len = val[3:0];
                pend_n  = 0;
            end
            sfr_pkg::CFG_PATTERN_BYTES: begin
                pat_bytes = val;
                pend_n    = 0;
            end
            sfr_pkg::CFG_REPLACEMENT_LENGTH: repl_len   = val[3:0];
            sfr_pkg::CFG_REPLACEMENT_BYTES:  repl_bytes = val;
            default: ;
        endcase
        cfg_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    int phase_idle  [PHASES] = '{0, 80, 0, 10, 0};
    int phase_stall [PHASES] = '{0, 0, 80, 10, 30};

    initial begin
        logic [7:0]  s0;
        logic [7:0]  s1;
        logic [7:0]  b;
        logic [63:0] pat;
        logic [3:0]  plen;
        logic [3:0]  rlen;
        int          cur;
        int          r;
        logic        fin;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                settle();
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                send_text(plan[i].text, plan[i].text_end, plan[i].known, plan[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            // two symbols make repeated bytes in the pattern likely
            s0 = 8'($urandom_range(255));
            s1 = 8'($urandom_range(255));
            for (int i = 0; i < 8; i++)
                pat[8 * i +: 8] = ($urandom_range(2) == 0) ? s1 : s0;
            plen = (p == 0) ? 4'd1 : (p == 1) ? 4'd8 : 4'($urandom_range(1, 8));
            rlen = (p == 0) ? 4'd8 : (p == 1) ? 4'd0 : 4'($urandom_range(0, 8));
            write_reg(sfr_pkg::CFG_PATTERN_LENGTH, 64'(plen));
            write_reg(sfr_pkg::CFG_PATTERN_BYTES, pat);
            write_reg(sfr_pkg::CFG_REPLACEMENT_LENGTH, 64'(rlen));
            write_reg(sfr_pkg::CFG_REPLACEMENT_BYTES, {32'($urandom), 32'($urandom)});
            if (p == PHASES - 1) begin
                fork
                    begin
                        hold_rx = 1'b1;
                        repeat (HOLD_CYCLES) @(posedge i_clk);
                        hold_rx = 1'b0;
                    end
                join_none
            end
            cur = 0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(99);
                if (r < 60) begin
                    // walk the pattern, sometimes restarting to break the match
                    b   = pat[8 * cur +: 8];
                    cur = ($urandom_range(9) == 0) ? 0 : (cur + 1) % int'(plen);
                end else if (r < 90) begin
                    b = ($urandom_range(1) == 0) ? s0 : s1;
                end else begin
                    b = 8'($urandom_range(255));
                end
                fin = ($urandom_range(11) == 0) || (k == PHASE_ITEMS - 1);
                send_text(b, fin, 1'b0, '0);
            end
        end

        push <= 1'b0;
        while (rewritten.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("run: %0d text bytes, %0d register writes, %0d words checked",
                 texts_sent, cfg_writes, words_seen);
        $display("input held off by a full queue on %0d cycles", full_waits);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
